FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the arp responder modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on an explicit clock, off while reset is high
`define ARP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// same check on the usual clock and reset names of this project
`define ARP_CHECK(label, prop, msg) \
   `ARP_ASSERT(label, clock, reset, prop, msg)

`endif

FILE: rtl/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Types, constants and byte helpers of the arp proxy responder.
// ----------------------------------------------------------------------------
package arp_pkg;

   localparam int MAC_W     = 48;
   localparam int IP_W      = 32;
   localparam int CNT_W     = 6;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = MAC_W;

   localparam logic [CNT_W-1:0] ARP_BYTES = 6'd42;
   localparam logic [CNT_W-1:0] LAST_IDX  = 6'd41;

   // byte positions inside the request / reply
   localparam logic [CNT_W-1:0] FIX_FIRST = 6'd12;
   localparam logic [CNT_W-1:0] FIX_END   = 6'd22;
   localparam logic [CNT_W-1:0] SHA_FIRST = 6'd22;
   localparam logic [CNT_W-1:0] SPA_FIRST = 6'd28;
   localparam logic [CNT_W-1:0] THA_FIRST = 6'd32;
   localparam logic [CNT_W-1:0] TPA_FIRST = 6'd38;
   localparam logic [CNT_W-1:0] OPCODE_LO = 6'd21;
   localparam logic [CNT_W-1:0] SMAC_FIRST = 6'd6;

   localparam logic [15:0] ETHERTYPE_ARP = 16'h0806;
   localparam logic [15:0] PROTO_IPV4    = 16'h0800;
   localparam logic [7:0]  OPER_REPLY_LO = 8'h02;

   localparam logic [1:0] VERDICT_REPLY    = 2'd0;
   localparam logic [1:0] VERDICT_SHORT    = 2'd1;
   localparam logic [1:0] VERDICT_MISMATCH = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_PROXY_MAC = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PROXY_IP  = 1'd1;

   typedef struct packed {
      logic [1:0]       verdict;
      logic [MAC_W-1:0] sender_hw;
      logic [IP_W-1:0]  sender_pa;
   } arp_evt_type;

   // expected request byte at positions 12..21 (opcode request at 21)
   function automatic logic [7:0] request_fixed(input logic [CNT_W-1:0] pos);
      logic [7:0] b;
      unique case (pos)
         6'd12:   b = ETHERTYPE_ARP[15:8];
         6'd13:   b = ETHERTYPE_ARP[7:0];
         6'd14:   b = 8'h00;
         6'd15:   b = 8'h01;
         6'd16:   b = PROTO_IPV4[15:8];
         6'd17:   b = PROTO_IPV4[7:0];
         6'd18:   b = 8'h06;
         6'd19:   b = 8'h04;
         6'd20:   b = 8'h00;
         default: b = 8'h01;
      endcase
      return b;
   endfunction

   // wire byte k of a mac address, k = 0 is bits 47..40
   function automatic logic [7:0] mac_byte(input logic [MAC_W-1:0] v, input logic [2:0] k);
      logic [MAC_W-1:0] sh;
      sh = v >> {(3'd5 - k), 3'b000};
      return sh[7:0];
   endfunction

   // wire byte k of an ipv4 address, k = 0 is bits 31..24
   function automatic logic [7:0] ip_byte(input logic [IP_W-1:0] v, input logic [1:0] k);
      logic [IP_W-1:0] sh;
      sh = v >> {(2'd3 - k), 3'b000};
      return sh[7:0];
   endfunction

endpackage

FILE: rtl/arp_if.sv
// ----------------------------------------------------------------------------
// arp_if
// Valid/ready channels of the arp responder: frame bytes in, results out.
// ----------------------------------------------------------------------------
interface arp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       rx_last;

   modport source (output valid, output rx_byte, output rx_last, input ready);
   modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

interface arp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic [1:0] verdict;
   logic       tx_last;

   modport source (output valid, output tx_byte, output verdict, output tx_last, input ready);
   modport sink   (input valid, input tx_byte, input verdict, input tx_last, output ready);
endinterface

FILE: rtl/arp_rx_parse.sv
// ----------------------------------------------------------------------------
// arp_rx_parse
// Per-byte request parser: position counter, header checks, sender address
// capture, and a one-entry frame-end event register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_rx_parse (
   input  logic                  clock,
   input  logic                  reset,
   arp_req_if.sink               req_if,
   input  logic [31:0]           proxy_ip,
   output logic                  evt_valid,
   output arp_pkg::arp_evt_type  evt,
   input  logic                  evt_take
);
   import arp_pkg::*;

   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic             still_matching_ff, still_matching_in;
   logic [MAC_W-1:0] sender_hw_ff, sender_hw_in;
   logic [IP_W-1:0]  sender_pa_ff, sender_pa_in;
   logic             evt_valid_ff, evt_valid_in;
   arp_evt_type      evt_ff, evt_in;

   logic             req_acc;
   logic             frame_end;
   logic             byte_ok;
   logic [CNT_W-1:0] tpa_off;

   // a frame end waits here until the generator takes it
   assign req_if.ready = !evt_valid_ff || evt_take;
   assign req_acc      = req_if.valid && req_if.ready;
   assign frame_end    = req_acc && req_if.rx_last;
   assign tpa_off      = byte_count_ff - TPA_FIRST;

   always_comb begin
      byte_ok = 1'b1;
      if (byte_count_ff >= FIX_FIRST && byte_count_ff < FIX_END) begin
         byte_ok = (req_if.rx_byte == request_fixed(byte_count_ff));
      end else if (byte_count_ff >= TPA_FIRST && byte_count_ff < ARP_BYTES) begin
         byte_ok = (req_if.rx_byte == ip_byte(proxy_ip, tpa_off[1:0]));
      end
   end

   always_comb begin
      byte_count_in     = byte_count_ff;
      still_matching_in = still_matching_ff;
      sender_hw_in      = sender_hw_ff;
      sender_pa_in      = sender_pa_ff;
      evt_valid_in      = evt_valid_ff && !evt_take;
      evt_in            = evt_ff;
      if (req_acc) begin
         if (byte_count_ff < ARP_BYTES) begin
            for (int i = 0; i < 6; i++) begin
               if (byte_count_ff == SHA_FIRST + CNT_W'(i))
                  sender_hw_in[8*(5-i) +: 8] = req_if.rx_byte;
            end
            for (int i = 0; i < 4; i++) begin
               if (byte_count_ff == SPA_FIRST + CNT_W'(i))
                  sender_pa_in[8*(3-i) +: 8] = req_if.rx_byte;
            end
            byte_count_in     = byte_count_ff + 1'b1;
            still_matching_in = still_matching_ff && byte_ok;
         end
         if (req_if.rx_last) begin
            evt_valid_in     = 1'b1;
            evt_in.sender_hw = sender_hw_in;
            evt_in.sender_pa = sender_pa_in;
            if (byte_count_in < ARP_BYTES)
               evt_in.verdict = VERDICT_SHORT;
            else if (!still_matching_in)
               evt_in.verdict = VERDICT_MISMATCH;
            else
               evt_in.verdict = VERDICT_REPLY;
            byte_count_in     = '0;
            still_matching_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff     <= '0;
         still_matching_ff <= 1'b1;
         sender_hw_ff      <= '0;
         sender_pa_ff      <= '0;
         evt_valid_ff      <= 1'b0;
      end else begin
         byte_count_ff     <= byte_count_in;
         still_matching_ff <= still_matching_in;
         sender_hw_ff      <= sender_hw_in;
         sender_pa_ff      <= sender_pa_in;
         evt_valid_ff      <= evt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      evt_ff <= evt_in;
   end

   assign evt_valid = evt_valid_ff;
   assign evt       = evt_ff;

   `ARP_CHECK(a_count_range, byte_count_ff <= ARP_BYTES, "byte count past frame length")
   `ARP_CHECK(a_frame_end_clears, frame_end |=> (byte_count_ff == '0 && still_matching_ff), "no clear")
   `ARP_CHECK(a_event_held, (evt_valid_ff && !evt_take) |=> (evt_valid_ff && $stable(evt_ff)), "event lost")

endmodule

FILE: rtl/arp_tx_gen.sv
// ----------------------------------------------------------------------------
// arp_tx_gen
// Result generator: turns a frame-end event into one status result or a
// 42-byte reply, through a registered output stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_tx_gen (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  evt_valid,
   input  arp_pkg::arp_evt_type  evt,
   output logic                  evt_take,
   input  logic [47:0]           proxy_mac,
   input  logic [31:0]           proxy_ip,
   arp_rsp_if.source             rsp_if
);
   import arp_pkg::*;

   logic             active_ff, active_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [MAC_W-1:0] sha_ff, sha_in;
   logic [IP_W-1:0]  spa_ff, spa_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       tx_byte_ff, tx_byte_in;
   logic [1:0]       verdict_ff, verdict_in;
   logic             tx_last_ff, tx_last_in;

   logic             out_free;
   logic             reply_end;
   logic             status_out;
   logic [7:0]       reply_byte;
   logic [CNT_W-1:0] off_smac, off_sha, off_tip, off_tha, off_tpa;

   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign evt_take = evt_valid && !active_ff && out_free;

   assign reply_end  = active_ff && out_free && (idx_ff == LAST_IDX);
   assign status_out = rsp_valid_ff && (verdict_ff != VERDICT_REPLY);

   assign off_smac = idx_ff - SMAC_FIRST;
   assign off_sha  = idx_ff - SHA_FIRST;
   assign off_tip  = idx_ff - SPA_FIRST;
   assign off_tha  = idx_ff - THA_FIRST;
   assign off_tpa  = idx_ff - TPA_FIRST;

   // reply layout: eth header, arp fixed fields, proxy as sender, requester as target
   always_comb begin
      priority if (idx_ff < SMAC_FIRST)
         reply_byte = mac_byte(sha_ff, idx_ff[2:0]);
      else if (idx_ff < FIX_FIRST)
         reply_byte = mac_byte(proxy_mac, off_smac[2:0]);
      else if (idx_ff == OPCODE_LO)
         reply_byte = OPER_REPLY_LO;
      else if (idx_ff < FIX_END)
         reply_byte = request_fixed(idx_ff);
      else if (idx_ff < SPA_FIRST)
         reply_byte = mac_byte(proxy_mac, off_sha[2:0]);
      else if (idx_ff < THA_FIRST)
         reply_byte = ip_byte(proxy_ip, off_tip[1:0]);
      else if (idx_ff < TPA_FIRST)
         reply_byte = mac_byte(sha_ff, off_tha[2:0]);
      else
         reply_byte = ip_byte(spa_ff, off_tpa[1:0]);
   end

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      sha_in       = sha_ff;
      spa_in       = spa_ff;
      rsp_valid_in = rsp_valid_ff;
      tx_byte_in   = tx_byte_ff;
      verdict_in   = verdict_ff;
      tx_last_in   = tx_last_ff;
      if (active_ff && out_free) begin
         rsp_valid_in = 1'b1;
         tx_byte_in   = reply_byte;
         verdict_in   = VERDICT_REPLY;
         tx_last_in   = (idx_ff == LAST_IDX);
         idx_in       = idx_ff + 1'b1;
         if (idx_ff == LAST_IDX)
            active_in = 1'b0;
      end else if (evt_take) begin
         if (evt.verdict == VERDICT_REPLY) begin
            // setup step to latch the requester addresses
            active_in    = 1'b1;
            idx_in       = '0;
            sha_in       = evt.sender_hw;
            spa_in       = evt.sender_pa;
            rsp_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b1;
            tx_byte_in   = '0;
            verdict_in   = evt.verdict;
            tx_last_in   = 1'b1;
         end
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sha_ff     <= sha_in;
      spa_ff     <= spa_in;
      tx_byte_ff <= tx_byte_in;
      verdict_ff <= verdict_in;
      tx_last_ff <= tx_last_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.tx_byte = tx_byte_ff;
   assign rsp_if.verdict = verdict_ff;
   assign rsp_if.tx_last = tx_last_ff;

   `ARP_CHECK(a_idx_range, active_ff |-> (idx_ff < ARP_BYTES), "reply index past frame length")
   `ARP_CHECK(a_status_single, status_out |-> (tx_last_ff && tx_byte_ff == '0), "bad status")
   `ARP_CHECK(a_reply_done, reply_end |=> (!active_ff && rsp_valid_ff && tx_last_ff), "bad reply end")

endmodule

FILE: rtl/arp_proxy_responder_unit.sv
// ----------------------------------------------------------------------------
// arp_proxy_responder_unit
// ARP proxy responder for IPv4 over Ethernet, byte-stream in and out.
// ----------------------------------------------------------------------------
// Frame bytes are taken one per clock unless the input stalls; the per-byte work
// is a position counter, a compare and a capture, done in the cycle the byte is
// accepted. A frame's final byte is held as an event until the generator is free.
// The generator turns it into either one status result (short frame or not a
// matching request), registered in the cycle after the event is taken, or a
// 42-byte ARP reply that starts after a setup step and then delivers one byte
// per clock while the output accepts it. Bytes of the next frame keep flowing
// while a reply goes out; once that frame's final byte waits as an event, the
// input stalls until the generator takes it. Registers proxy_mac (index 0) and
// proxy_ip (index 1) are written through the csr port; the user must do so only
// while the block is idle, which the block does not enforce. No clearing pass after reset.
module arp_proxy_responder_unit (
   input  logic                                clock,
   input  logic                                reset,
   arp_req_if.sink                             req_if,
   arp_rsp_if.source                           rsp_if,
   input  logic                                csr_we,
   input  logic [arp_pkg::CSR_IDX_W-1:0]       csr_idx,
   input  logic [arp_pkg::CSR_DAT_W-1:0]       csr_wdata
);
   import arp_pkg::*;

   logic [MAC_W-1:0] proxy_mac_ff;
   logic [IP_W-1:0]  proxy_ip_ff;
   logic             evt_valid;
   logic             evt_take;
   arp_evt_type      evt;

   always_ff @(posedge clock) begin
      if (reset) begin
         proxy_mac_ff <= '0;
         proxy_ip_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_idx)
            CSR_PROXY_MAC: proxy_mac_ff <= csr_wdata;
            CSR_PROXY_IP:  proxy_ip_ff  <= csr_wdata[IP_W-1:0];
            default:       ;
         endcase
      end
   end

   arp_rx_parse u_rx_parse (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .proxy_ip   (proxy_ip_ff),
      .evt_valid  (evt_valid),
      .evt        (evt),
      .evt_take   (evt_take)
   );

   arp_tx_gen u_tx_gen (
      .clock      (clock),
      .reset      (reset),
      .evt_valid  (evt_valid),
      .evt        (evt),
      .evt_take   (evt_take),
      .proxy_mac  (proxy_mac_ff),
      .proxy_ip   (proxy_ip_ff),
      .rsp_if     (rsp_if)
   );

endmodule
